>>> design/tria_pkg.sv
// Shared types and constants for the two-resource interval assigner.
package tria_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 64;
  localparam int unsigned TIME_BITS         = 16;
  localparam int unsigned IDX_W             = 6;
  localparam int unsigned STATUS_W          = 2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ASSIGNED   = 2'd0,
    STAT_IMPOSSIBLE = 2'd1,
    STAT_TOO_MANY   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ASSIGN,
    ST_DRAIN,
    ST_EMIT,
    ST_SINGLE
  } state_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic                 last;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] interval_index;
    logic             resource;
    status_e          status;
    logic             last_result;
  } out_beat_t;

  // One interval as held in the sorting chain.
  typedef struct packed {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic [IDX_W-1:0]     idx;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } chain_cmd_t;

endpackage

>>> design/tria_sort_cell.sv
// One cell of the insertion sorting chain.
module tria_sort_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tria_pkg::chain_cmd_t cmd_i,
  input  tria_pkg::entry_t    new_i,
  input  tria_pkg::entry_t    left_i,
  input  logic                left_valid_i,
  input  logic                left_keep_i,
  input  tria_pkg::entry_t    right_i,
  input  logic                right_valid_i,
  output logic                valid_o,
  output logic                keep_o,
  output tria_pkg::entry_t    entry_o
);
  import tria_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  // Held entry stays put when its start is not later than the new one (stable order).
  assign keep_o  = valid_q && (entry_q.start_time <= new_i.start_time);
  assign valid_o = valid_q;
  assign entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.shift) begin
      valid_d = right_valid_i;
      entry_d = right_i;
    end else if (cmd_i.load && !keep_o) begin
      if (left_keep_i) begin
        valid_d = 1'b1;
        entry_d = new_i;
      end else begin
        valid_d = left_valid_i;
        entry_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> design/tria_sort_chain.sv
// Row of sorting cells: inserts by start time, drains from the head.
module tria_sort_chain #(
  parameter int unsigned MAX_INTERVALS = tria_pkg::MAX_INTERVALS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tria_pkg::chain_cmd_t cmd_i,
  input  tria_pkg::entry_t     new_i,
  output logic                 head_valid_o,
  output tria_pkg::entry_t     head_o
);
  import tria_pkg::*;

  entry_t entry_w [MAX_INTERVALS];
  logic   valid_w [MAX_INTERVALS];
  logic   keep_w  [MAX_INTERVALS];

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_v, left_k, right_v;

    if (i == 0) begin : g_first
      assign left_e = new_i;
      assign left_v = 1'b1;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = entry_w[i-1];
      assign left_v = valid_w[i-1];
      assign left_k = keep_w[i-1];
    end

    if (i == MAX_INTERVALS - 1) begin : g_tail
      assign right_e = '0;
      assign right_v = 1'b0;
    end else begin : g_body
      assign right_e = entry_w[i+1];
      assign right_v = valid_w[i+1];
    end

    tria_sort_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .new_i        (new_i),
      .left_i       (left_e),
      .left_valid_i (left_v),
      .left_keep_i  (left_k),
      .right_i      (right_e),
      .right_valid_i(right_v),
      .valid_o      (valid_w[i]),
      .keep_o       (keep_w[i]),
      .entry_o      (entry_w[i])
    );
  end

  assign head_valid_o = valid_w[0];
  assign head_o       = entry_w[0];

endmodule

>>> design/two_resource_interval_assigner_core.sv
// Two-resource interval assigner: sorting chain, greedy assign pass, result emitter.
//
// Input channel (in_valid_i / in_stall_o / in_i): one interval per beat, start and
// end time, last set on the final interval of a set. Intervals load one per cycle
// into a row of sorting cells that keeps them in stable start-time order.
// in_stall_o is high from the cycle after the last beat until the set's results
// have all been handed to the output register.
// After the last beat the head of the chain is drained one interval per cycle
// through the greedy test against the two resource end times, writing the
// chosen resource into a small bit memory by index. After a drain state,
// results leave in arrival order through the output register, one per cycle
// while the receiver does not stall.
// Impossible sets and sets of more than MAX_INTERVALS give a single result.
// Output channel (out_valid_o / out_stall_i / out_o) is fed from a register
// that holds its beat while out_stall_i is high; the emitter waits on it.
// Reset empties the chain and the set counters; the bit memory needs no clear.
module two_resource_interval_assigner_core #(
  parameter int unsigned MAX_INTERVALS = tria_pkg::MAX_INTERVALS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tria_pkg::in_beat_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tria_pkg::out_beat_t out_o
);
  import tria_pkg::*;

  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned AW = $clog2(MAX_INTERVALS);

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        n_q, n_d;
  logic [CW-1:0]        a_q, a_d;
  logic [CW-1:0]        e_q, e_d;
  logic                 ovf_q, ovf_d;
  logic [TIME_BITS-1:0] end0_q, end0_d, end1_q, end1_d;
  status_e              stat_q, stat_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  logic       in_acc, full, slot_free;
  chain_cmd_t cmd;
  entry_t     new_e, head;
  logic       head_valid;
  logic       mem_we, mem_wd, bit_q;
  logic       asg_mem [MAX_INTERVALS];

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q >= CW'(MAX_INTERVALS));
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign new_e.start_time = in_i.start_time;
  assign new_e.end_time   = in_i.end_time;
  assign new_e.idx        = IDX_W'(count_q);

  tria_sort_chain #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .new_i       (new_e),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    a_d         = a_q;
    e_d         = '0;
    ovf_d       = ovf_q;
    end0_d      = end0_q;
    end1_d      = end1_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd         = '0;
    mem_we      = 1'b0;
    mem_wd      = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cmd.load = 1'b1;
            count_d  = count_q + CW'(1);
          end
          if (in_i.last) begin
            end0_d = '0;
            end1_d = '0;
            a_d    = '0;
            if (ovf_q || full) begin
              stat_d  = STAT_TOO_MANY;
              state_d = ST_SINGLE;
            end else begin
              n_d     = count_q + CW'(1);
              state_d = ST_ASSIGN;
            end
          end
        end
      end
      ST_ASSIGN: begin
        cmd.shift = 1'b1;
        if (head.start_time >= end0_q) begin
          end0_d = head.end_time;
          mem_we = 1'b1;
          mem_wd = 1'b0;
        end else if (head.start_time >= end1_q) begin
          end1_d = head.end_time;
          mem_we = 1'b1;
          mem_wd = 1'b1;
        end else begin
          stat_d  = STAT_IMPOSSIBLE;
          state_d = ST_SINGLE;
        end
        if (mem_we) begin
          if (a_q == n_q - CW'(1)) begin
            state_d = ST_DRAIN;
          end else begin
            a_d = a_q + CW'(1);
          end
        end
      end
      ST_DRAIN: begin
        // last memory write has landed; bit for index 0 is fetched now
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        e_d = e_q;
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.interval_index = IDX_W'(e_q);
          out_d.resource       = bit_q;
          out_d.status         = STAT_ASSIGNED;
          out_d.last_result    = (e_q == n_q - CW'(1));
          if (e_q == n_q - CW'(1)) begin
            e_d       = '0;
            cmd.clear = 1'b1;
            count_d   = '0;
            ovf_d     = 1'b0;
            state_d   = ST_LOAD;
          end else begin
            e_d = e_q + CW'(1);
          end
        end
      end
      ST_SINGLE: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.interval_index = '0;
          out_d.resource       = 1'b0;
          out_d.status         = stat_q;
          out_d.last_result    = 1'b1;
          cmd.clear            = 1'b1;
          count_d              = '0;
          ovf_d                = 1'b0;
          state_d              = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      n_q         <= '0;
      a_q         <= '0;
      e_q         <= '0;
      ovf_q       <= 1'b0;
      end0_q      <= '0;
      end1_q      <= '0;
      stat_q      <= STAT_ASSIGNED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      a_q         <= a_d;
      e_q         <= e_d;
      ovf_q       <= ovf_d;
      end0_q      <= end0_d;
      end1_q      <= end1_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Resource bit per arrival index; read address runs one step ahead of e_q.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      asg_mem[head.idx[AW-1:0]] <= mem_wd;
    end
    bit_q <= asg_mem[e_d[AW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ASSIGN |-> head_valid)
    else $error("assign pass ran past the end of the chain");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_INTERVALS))
    else $error("loaded count above capacity");

  a_last_leaves_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last |=> state_q != ST_LOAD && count_q != '0)
    else $error("set did not close after last beat");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> e_q < n_q)
    else $error("emit index beyond set size");
`endif

endmodule
